>>> sv/utf8_stream_decoder_defines.svh
// Assertion macros shared by the decoder RTL files.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Plain property, checked on every clock outside reset.
`define U8SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked on every clock outside reset.
`define U8SD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/u8sd_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
package u8sd_pkg;

  // Default depth of the result queue.
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned CP_W  = 31;
  localparam int unsigned LEN_W = 3;

  // Result kind, carried on tuser.
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // One result word.
  typedef struct packed {
    kind_e             kind;
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  seq_length;
    logic              last;
  } result_t;

  // Results caused by one input byte: res0 first, then res1.
  typedef struct packed {
    logic [1:0] num;
    result_t    res1;
    result_t    res0;
  } step_t;

endpackage

>>> sv/utf8_stream_decoder.sv
// UTF-8 stream decoder (FSS-UTF, 1 to 6 byte sequences): top level.
//
// Input stream: one byte per word on s_axis; tlast marks the last available
// byte. Output stream: result words on m_axis; tuser holds the kind (code
// point, dropped sequence, end of string), tdata holds code point and
// sequence length, tlast marks the last result caused by one input byte.
// A byte yields zero, one or two results.
// A byte accepted on s_axis waits in the input register until the result
// queue has room, then is decoded into the queue, whose head drives m_axis.
// Throughput: one byte per cycle while results drain one per cycle; a byte
// that yields two results puts two words into the queue. The input register
// advances only when the result queue has room for two words, so the queue
// depth sets how far the input runs ahead of a stalled receiver.
// When the receiver stalls, results wait in the queue and s_axis_tready
// falls once the queue is nearly full; nothing is lost or repeated.
// Reset clears the sequence state, the input register and the queue; the
// block is ready for bytes as soon as reset is released.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder import u8sd_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // final_req
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [30:0] code_point, [33:31] seq_length, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;
  logic       adv;
  logic       room;
  logic       in_accept;

  // Result queue
  result_t         queue_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr1;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      push_n;
  logic            pop;
  step_t           step;
  result_t         head;

  assign room          = (count_q <= CntW'(FifoDepth - 2));
  assign adv           = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Capture one byte; drop it once decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q  <= s_axis_tdata;
      in_final_q <= s_axis_tlast;
    end
  end

  u8sd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .final_i (in_final_q),
    .step_o  (step)
  );

  assign push_n  = adv ? step.num : 2'd0;
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign wr_ptr1 = ptr_inc(wr_ptr_q);
  assign count_d = count_q + CntW'(push_n) - CntW'(pop);

  always_comb begin
    unique case (push_n)
      2'd1:    wr_ptr_d = wr_ptr1;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
  end

  // Advance queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
    end
  end

  // Write up to two results per byte.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= step.res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr1] <= step.res1;
    end
  end

  // Present the queue head.
  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {6'b0, head.seq_length, head.code_point};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  `U8SD_ASSERT(a_count_bound, count_q <= CntW'(FifoDepth), "result queue overflow")
  `U8SD_ASSERT_IMP(a_push_room, push_n != 2'd0, room, "push without room for two words")
  `U8SD_ASSERT_IMP(a_empty_no_pop, count_q == '0, !pop, "pop from an empty queue")

endmodule

>>> sv/u8sd_decode.sv
// Decode state and per-byte result logic of the UTF-8 stream decoder.
`include "utf8_stream_decoder_defines.svh"

module u8sd_decode import u8sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,      // consume byte_i this cycle
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output step_t      step_o
);

  typedef struct packed {
    logic              emit;
    kind_e             kind;
    logic [CP_W-1:0]   cp;
    logic [LEN_W-1:0]  len;
    logic [CP_W-1:0]   partial;
    logic [LEN_W-1:0]  owed;
    logic [LEN_W-1:0]  seqlen;
  } idle_t;

  // Smallest value that a sequence of the given length may carry.
  function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      3'd2:    v = 31'h0000080;
      3'd3:    v = 31'h0000800;
      3'd4:    v = 31'h0010000;
      3'd5:    v = 31'h0200000;
      3'd6:    v = 31'h4000000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Byte seen with no sequence in progress.
  function automatic idle_t idle_decode(input logic [7:0] b, input logic fin);
    idle_t            r;
    logic [LEN_W-1:0] ln;
    logic [5:0]       msk;
    r      = '0;
    r.kind = KIND_CHAR;
    ln     = 3'd6;
    msk    = 6'h01;
    if (b == 8'h00) begin
      r.emit = 1'b1;
      r.kind = KIND_END;
      r.len  = 3'd1;
    end else if (!b[7]) begin
      r.emit = 1'b1;
      r.cp   = {{(CP_W-8){1'b0}}, b};
      r.len  = 3'd1;
    end else if (!b[6] || (b[7:1] == 7'b1111111)) begin
      // stray continuation, or 0xFE / 0xFF
      r.emit = 1'b1;
      r.kind = KIND_ERROR;
      r.len  = 3'd1;
    end else begin
      if (!b[5]) begin
        ln = 3'd2; msk = 6'h1F;
      end else if (!b[4]) begin
        ln = 3'd3; msk = 6'h0F;
      end else if (!b[3]) begin
        ln = 3'd4; msk = 6'h07;
      end else if (!b[2]) begin
        ln = 3'd5; msk = 6'h03;
      end
      if (fin) begin
        // lead byte with nothing after it
        r.emit = 1'b1;
        r.kind = KIND_ERROR;
        r.len  = 3'd1;
      end else begin
        r.partial = {{(CP_W-6){1'b0}}, b[5:0] & msk};
        r.owed    = ln - 3'd1;
        r.seqlen  = ln;
      end
    end
    return r;
  endfunction

  logic [CP_W-1:0]  partial_q, partial_d;
  logic [LEN_W-1:0] owed_q, owed_d;
  logic [LEN_W-1:0] len_q, len_d;

  idle_t            idle;
  logic             is_cont;
  logic [CP_W-1:0]  pv;
  logic [LEN_W-1:0] owed_dec;
  step_t            step;

  assign idle     = idle_decode(byte_i, final_i);
  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign pv       = {partial_q[CP_W-7:0], byte_i[5:0]};
  assign owed_dec = owed_q - 3'd1;

  // Build the results of this byte and the next state.
  always_comb begin
    step           = '0;
    step.res0.kind = KIND_CHAR;
    step.res1.kind = KIND_CHAR;
    partial_d      = '0;
    owed_d         = '0;
    len_d          = '0;
    if (owed_q == '0) begin
      partial_d = idle.partial;
      owed_d    = idle.owed;
      len_d     = idle.seqlen;
      if (idle.emit) begin
        step.num             = 2'd1;
        step.res0.kind       = idle.kind;
        step.res0.code_point = idle.cp;
        step.res0.seq_length = idle.len;
      end
    end else if (is_cont) begin
      if (owed_dec == '0) begin
        step.num             = 2'd1;
        step.res0.seq_length = len_q;
        if (pv < min_value(len_q)) begin
          step.res0.kind = KIND_ERROR;
        end else begin
          step.res0.code_point = pv;
        end
      end else if (final_i) begin
        step.num             = 2'd1;
        step.res0.kind       = KIND_ERROR;
        step.res0.seq_length = len_q - owed_dec;
      end else begin
        partial_d = pv;
        owed_d    = owed_dec;
        len_d     = len_q;
      end
    end else begin
      // broken sequence: drop it, then take this byte as a new lead
      step.num             = 2'd1;
      step.res0.kind       = KIND_ERROR;
      step.res0.seq_length = len_q - owed_q;
      partial_d            = idle.partial;
      owed_d               = idle.owed;
      len_d                = idle.seqlen;
      if (idle.emit) begin
        step.num             = 2'd2;
        step.res1.kind       = idle.kind;
        step.res1.code_point = idle.cp;
        step.res1.seq_length = idle.len;
      end
    end
    // mark the final result of this byte
    if (step.num == 2'd1) begin
      step.res0.last = 1'b1;
    end else if (step.num == 2'd2) begin
      step.res1.last = 1'b1;
    end
  end

  assign step_o = step;

  // Hold sequence state; advance on each consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      owed_q    <= '0;
      len_q     <= '0;
    end else if (adv_i) begin
      partial_q <= partial_d;
      owed_q    <= owed_d;
      len_q     <= len_d;
    end
  end

  `U8SD_ASSERT_IMP(a_state_consistent, owed_q != '0, (len_q > owed_q) && (len_q >= 3'd2), "owed count exceeds sequence length")
  `U8SD_ASSERT_IMP(a_second_after_error, step.num == 2'd2, step.res0.kind == KIND_ERROR, "two results without a leading error")
  `U8SD_ASSERT_IMP(a_ascii_single, (owed_q == '0) && !byte_i[7], step.num == 2'd1, "ASCII byte must give exactly one result")

endmodule

>>> verif/utf8_stream_decoder_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 stream decoder: predicts each result word and checks it.
module utf8_stream_decoder_checker import u8sd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,    // [7:0] byte_value
  input  logic        s_last_i,    // final_req
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,    // [30:0] code_point, [33:31] seq_length
  input  logic [1:0]  m_user_i,    // [1:0] kind
  input  logic        m_last_i,    // last_of_run
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  // Sequence state of the decoder as predicted
  logic [CP_W-1:0]  acc_cp;
  logic [LEN_W-1:0] owed_cnt;
  logic [LEN_W-1:0] seq_len;

  // Results caused by the current byte, then all results not yet seen
  result_t byte_results[$];
  result_t pending_results[$];

  int unsigned fail_cnt;
  int unsigned pending_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_cnt;

  // Smallest value a sequence of the given length may carry
  function automatic logic [CP_W-1:0] shortest_form_min(input logic [LEN_W-1:0] len);
    case (len)
      3'd2:    return 31'h80;
      3'd3:    return 31'h800;
      3'd4:    return 31'h10000;
      3'd5:    return 31'h200000;
      3'd6:    return 31'h4000000;
      default: return '0;
    endcase
  endfunction

  function automatic result_t result_of(input kind_e kind, input logic [CP_W-1:0] cp,
                                        input logic [LEN_W-1:0] len);
    result_t r;
    r.kind       = kind;
    r.code_point = cp;
    r.seq_length = len;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic clear_seq();
    acc_cp   = '0;
    owed_cnt = '0;
    seq_len  = '0;
  endtask

  // Handle a byte with no sequence in progress
  task automatic take_lead(input logic [7:0] b, input logic fin);
    logic [LEN_W-1:0] len;
    logic [7:0]       mask;
    if (b == 8'h00) begin
      byte_results.push_back(result_of(KIND_END, '0, 3'd1));
    end else if (b < 8'h80) begin
      byte_results.push_back(result_of(KIND_CHAR, {23'd0, b}, 3'd1));
    end else if (b[7:6] == 2'b10 || b >= 8'hFE) begin
      byte_results.push_back(result_of(KIND_ERROR, '0, 3'd1));
    end else begin
      if (!b[5]) begin
        len = 3'd2; mask = 8'h1F;
      end else if (!b[4]) begin
        len = 3'd3; mask = 8'h0F;
      end else if (!b[3]) begin
        len = 3'd4; mask = 8'h07;
      end else if (!b[2]) begin
        len = 3'd5; mask = 8'h03;
      end else begin
        len = 3'd6; mask = 8'h01;
      end
      // A lead byte that is also the last byte leaves the sequence cut short
      if (fin) begin
        clear_seq();
        byte_results.push_back(result_of(KIND_ERROR, '0, 3'd1));
      end else begin
        acc_cp   = {23'd0, b & mask};
        owed_cnt = len - 3'd1;
        seq_len  = len;
      end
    end
  endtask

  // Advance the prediction by one accepted byte and queue its results
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [LEN_W-1:0] taken;
    byte_results.delete();
    if (owed_cnt == 0) begin
      take_lead(b, fin);
    end else if (b[7:6] == 2'b10) begin
      acc_cp   = {acc_cp[CP_W-7:0], b[5:0]};
      owed_cnt = owed_cnt - 3'd1;
      if (owed_cnt == 0) begin
        // Sequence complete: reject overlong forms
        if (acc_cp < shortest_form_min(seq_len))
          byte_results.push_back(result_of(KIND_ERROR, '0, seq_len));
        else
          byte_results.push_back(result_of(KIND_CHAR, acc_cp, seq_len));
        clear_seq();
      end else if (fin) begin
        taken = seq_len - owed_cnt;
        clear_seq();
        byte_results.push_back(result_of(KIND_ERROR, '0, taken));
      end
    end else begin
      // Broken sequence: drop what was taken, then restart on this byte
      taken = seq_len - owed_cnt;
      clear_seq();
      byte_results.push_back(result_of(KIND_ERROR, '0, taken));
      take_lead(b, fin);
    end
    if (byte_results.size() > 0)
      byte_results[byte_results.size()-1].last = 1'b1;
    foreach (byte_results[i])
      pending_results.push_back(byte_results[i]);
  endtask

  // Watch both channels, predict on input words, compare on result words
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_seq();
      pending_results.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
    end else begin
      if (s_valid_i && s_ready_i)
        decode_byte(s_data_i, s_last_i);
      if (m_valid_i && m_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: kind %0d code_point %0h seq_length %0d",
                 m_user_i, m_data_i[30:0], m_data_i[33:31]);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (m_user_i != want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, m_user_i);
            fail_cnt++;
          end
          if (m_data_i[30:0] != want.code_point) begin
            $error("code_point: expected %0h, actual %0h", want.code_point, m_data_i[30:0]);
            fail_cnt++;
          end
          if (m_data_i[33:31] != want.seq_length) begin
            $error("seq_length: expected %0d, actual %0d", want.seq_length, m_data_i[33:31]);
            fail_cnt++;
          end
          if (m_last_i != want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, m_last_i);
            fail_cnt++;
          end
        end
      end
      pending_cnt = pending_results.size();
    end
  end

endmodule

>>> verif/utf8_stream_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 stream decoder: clock, reset, stimulus and verdict.
module utf8_stream_decoder_tb;
  import u8sd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] byte_value
  logic        s_axis_tlast = 1'b0;     // final_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;            // [30:0] code_point, [33:31] seq_length
  logic [1:0]  m_axis_tuser;            // [1:0] kind
  logic        m_axis_tlast;            // last_of_run

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned bytes_sent = 0;
  int unsigned results_taken = 0;
  bit          calm = 1'b0;
  bit          hold_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  utf8_stream_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  utf8_stream_decoder_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_last_i   (s_axis_tlast),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .m_user_i   (m_axis_tuser),
    .m_last_i   (m_axis_tlast),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  // Value range of an encoding of the given length
  function automatic logic [30:0] len_min(input int len);
    case (len)
      2:       return 31'h80;
      3:       return 31'h800;
      4:       return 31'h10000;
      5:       return 31'h200000;
      6:       return 31'h4000000;
      default: return 31'h0;
    endcase
  endfunction

  function automatic logic [30:0] len_max(input int len);
    case (len)
      1:       return 31'h7F;
      2:       return 31'h7FF;
      3:       return 31'hFFFF;
      4:       return 31'h1FFFFF;
      5:       return 31'h3FFFFFF;
      default: return 31'h7FFFFFFF;
    endcase
  endfunction

  // Byte idx of the encoding of cp in len bytes
  function automatic logic [7:0] enc_byte(input logic [30:0] cp, input int len, input int idx);
    logic [30:0] part;
    logic [7:0]  lead_tag;
    part = cp >> (6 * (len - 1 - idx));
    if (idx > 0)
      return 8'h80 | {2'b00, part[5:0]};
    case (len)
      2:       lead_tag = 8'hC0;
      3:       lead_tag = 8'hE0;
      4:       lead_tag = 8'hF0;
      5:       lead_tag = 8'hF8;
      6:       lead_tag = 8'hFC;
      default: lead_tag = 8'h00;
    endcase
    return lead_tag | part[7:0];
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send the first cut bytes of an encoding, now and then flagged as last
  task automatic send_code(input logic [30:0] cp, input int len, input int cut);
    for (int i = 0; i < cut; i++)
      send_byte(enc_byte(cp, len, i), $urandom_range(0, 29) == 0);
  endtask

  // Receiver: random stalls per word, one long hold-off to back up the input
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!hold_done && results_taken >= 400) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
      @(negedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    int          pick;
    int          len;
    logic [30:0] cp;
    int unsigned next_mode_at;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: ASCII, end marker, longest maximal form, errors of each sort
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_code(31'h7FFFFFFF, 6, 6);
    send_byte(8'h80, 1'b0);             // stray continuation
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC3, 1'b0);             // broken by a plain byte
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b1);             // lead byte cut short
    send_byte(8'hE2, 1'b0);             // cut short after a continuation
    send_byte(8'h82, 1'b1);
    send_byte(8'hC0, 1'b0);             // overlong form
    send_byte(8'h80, 1'b0);
    send_code(31'h1F600, 4, 4);

    // Random: mostly well-formed sequences, some overlong, cut or noise
    next_mode_at = bytes_sent + 100;
    while (bytes_sent < 1800) begin
      if (bytes_sent >= next_mode_at) begin
        calm = ($urandom_range(0, 3) == 0);
        next_mode_at = bytes_sent + 100;
      end
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0:       cp = len_min(len);
        1:       cp = len_max(len);
        default: cp = 31'($urandom_range(len_min(len), len_max(len)));
      endcase
      if (pick < 70) begin
        send_code(cp, len, len);
      end else if (pick < 78) begin
        len = $urandom_range(2, 6);
        send_code(31'($urandom_range(0, len_min(len) - 1)), len, len);
      end else if (pick < 90) begin
        len = $urandom_range(2, 6);
        send_code(31'($urandom_range(len_min(len), len_max(len))), len,
                  $urandom_range(1, len - 1));
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for any stray late word
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
